// ===== hdl/a5_1_stream_cipher_core_defines.svh =====
// Assertion helpers for the A5/1 core.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef A5_1_STREAM_CIPHER_CORE_DEFINES_SVH
`define A5_1_STREAM_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTH
// cond holds at every rising clock edge outside reset
`define A51_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("a5/1 core: assertion failed");
// ante in this cycle implies cons in the next
`define A51_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("a5/1 core: assertion failed");
`else
`define A51_ASSERT(lbl, cond)
`define A51_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/a51_pkg.sv =====
package a51_pkg;

	localparam int KEY_W   = 64;
	localparam int FRAME_W = 22;
	localparam int R1_W    = 19;
	localparam int R2_W    = 22;
	localparam int R3_W    = 23;
	localparam int CNT_W   = 8;   // covers key bits, frame bits and up to 255 warmup clocks
	localparam int KIDX_W  = 6;   // index into the 64-bit key
	localparam int FIDX_W  = 5;   // index into the 22-bit frame number
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [R1_W-1:0] R1_TAPS = R1_W'((1 << 18) | (1 << 17) | (1 << 16) | (1 << 13));
	localparam logic [R2_W-1:0] R2_TAPS = R2_W'((1 << 21) | (1 << 20));
	localparam logic [R3_W-1:0] R3_TAPS = R3_W'((1 << 22) | (1 << 21) | (1 << 20) | (1 << 7));

	localparam logic [CFG_IDX_W-1:0] CFG_KEY   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME = CFG_IDX_W'(1);

	localparam logic [CNT_W-1:0] KEY_LAST  = CNT_W'(KEY_W - 1);
	localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(7);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_IV,
		ST_WARM,
		ST_GEN
	} a51_state_t;

	typedef struct packed {
		logic                load_data;  // capture the accepted byte
		logic                clear;      // zero all three registers
		logic                inject;     // xor a load bit into bit 0, then step all
		logic                use_iv;     // load bit comes from the frame number
		logic [KIDX_W-1:0]   bit_idx;
		logic                maj_clk;    // one majority-rule clock
		logic                ks_shift;   // sample keystream bit before the clock
		logic                ks_last;    // eighth bit: write the result byte
	} a51_cmd_t;

	function automatic logic [R1_W-1:0] step_r1(input logic [R1_W-1:0] r);
		return {r[R1_W-2:0], ^(r & R1_TAPS)};
	endfunction

	function automatic logic [R2_W-1:0] step_r2(input logic [R2_W-1:0] r);
		return {r[R2_W-2:0], ^(r & R2_TAPS)};
	endfunction

	function automatic logic [R3_W-1:0] step_r3(input logic [R3_W-1:0] r);
		return {r[R3_W-2:0], ^(r & R3_TAPS)};
	endfunction

endpackage

// ===== hdl/a51_ctrl.sv =====
`include "a5_1_stream_cipher_core_defines.svh"

module a51_ctrl import a51_pkg::*; #(
	parameter int WARMUP_CLOCKS = 100,
	parameter int IV_BITS       = 22
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     frame_start,
	output logic     out_valid,
	input  logic     out_ready,
	output a51_cmd_t cmd
);

	localparam logic [CNT_W-1:0] IV_LAST   = CNT_W'(IV_BITS - 1);
	localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'((WARMUP_CLOCKS > 0) ? WARMUP_CLOCKS - 1 : 0);

	a51_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              out_valid_q;
	logic              in_accept;
	logic              slot_free;
	logic              gen_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign gen_last  = (state_q == ST_GEN) && (count_q == BYTE_LAST);
	assign out_valid = out_valid_q;

	// next state and counter
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = frame_start ? ST_KEY : ST_GEN;
					count_d = '0;
				end
			end
			ST_KEY: begin
				if (count_q == KEY_LAST) begin
					state_d = ST_IV;
					count_d = '0;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			ST_IV: begin
				if (count_q == IV_LAST) begin
					state_d = (WARMUP_CLOCKS > 0) ? ST_WARM : ST_GEN;
					count_d = '0;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			ST_WARM: begin
				if (count_q == WARM_LAST) begin
					state_d = ST_GEN;
					count_d = '0;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			ST_GEN: begin
				if (count_q == BYTE_LAST) begin
					// last bit waits for the output register to free up
					if (slot_free) begin
						state_d = ST_IDLE;
						count_d = '0;
					end
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
				count_d = '0;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_data = in_accept;
				cmd.clear     = in_accept && frame_start;
			end
			ST_KEY: begin
				cmd.inject  = 1'b1;
				cmd.bit_idx = count_q[KIDX_W-1:0];
			end
			ST_IV: begin
				cmd.inject  = 1'b1;
				cmd.use_iv  = 1'b1;
				cmd.bit_idx = count_q[KIDX_W-1:0];
			end
			ST_WARM: begin
				cmd.maj_clk = 1'b1;
			end
			ST_GEN: begin
				if (!gen_last || slot_free) begin
					cmd.maj_clk  = 1'b1;
					cmd.ks_shift = 1'b1;
					cmd.ks_last  = gen_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cmd.ks_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`A51_ASSERT_NEXT(a_frame_enters_key, in_accept && frame_start, state_q == ST_KEY && count_q == '0)
	`A51_ASSERT_NEXT(a_key_to_iv, state_q == ST_KEY && count_q == KEY_LAST, state_q == ST_IV)
	`A51_ASSERT_NEXT(a_last_bit_stall, gen_last && !slot_free, gen_last && $stable(count_q))
	`A51_ASSERT_NEXT(a_result_posted, cmd.ks_last, out_valid_q && state_q == ST_IDLE)

endmodule

// ===== hdl/a51_datapath.sv =====
module a51_datapath import a51_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  a51_cmd_t              cmd,
	input  logic [7:0]            data_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [7:0]            out_byte
);

	logic [KEY_W-1:0]   key_q;
	logic [FRAME_W-1:0] frame_q;
	logic [R1_W-1:0]    r1_q;
	logic [R2_W-1:0]    r2_q;
	logic [R3_W-1:0]    r3_q;
	logic [7:0]         data_q;
	logic [7:0]         ks_q;
	logic [7:0]         out_q;

	logic               load_bit;
	logic [R1_W-1:0]    r1_inj;
	logic [R2_W-1:0]    r2_inj;
	logic [R3_W-1:0]    r3_inj;
	logic               ca, cb, cc, maj;
	logic               ks_bit;
	logic [7:0]         ks_next;

	assign load_bit = cmd.use_iv ? frame_q[cmd.bit_idx[FIDX_W-1:0]] : key_q[cmd.bit_idx];
	assign r1_inj   = r1_q ^ {{(R1_W-1){1'b0}}, load_bit};
	assign r2_inj   = r2_q ^ {{(R2_W-1){1'b0}}, load_bit};
	assign r3_inj   = r3_q ^ {{(R3_W-1){1'b0}}, load_bit};

	// clocking bits and the majority vote
	assign ca  = r1_q[8];
	assign cb  = r2_q[10];
	assign cc  = r3_q[10];
	assign maj = (ca & cb) | (ca & cc) | (cb & cc);

	assign ks_bit  = r1_q[R1_W-1] ^ r2_q[R2_W-1] ^ r3_q[R3_W-1];
	assign ks_next = {ks_bit, ks_q[7:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			frame_q <= '0;
			r1_q    <= '0;
			r2_q    <= '0;
			r3_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_KEY) begin
				key_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_FRAME) begin
				frame_q <= cfg_data[FRAME_W-1:0];
			end
			// clear, inject and maj_clk are exclusive by phase; cycles with none of them hold the registers
			if (cmd.clear) begin
				r1_q <= '0;
				r2_q <= '0;
				r3_q <= '0;
			end else if (cmd.inject) begin
				r1_q <= step_r1(r1_inj);
				r2_q <= step_r2(r2_inj);
				r3_q <= step_r3(r3_inj);
			end else if (cmd.maj_clk) begin
				if (ca == maj) r1_q <= step_r1(r1_q);
				if (cb == maj) r2_q <= step_r2(r2_q);
				if (cc == maj) r3_q <= step_r3(r3_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			data_q <= data_byte;
		end
		if (cmd.ks_shift) begin
			ks_q <= ks_next;
		end
		if (cmd.ks_last) begin
			out_q <= data_q ^ ks_next;
		end
	end

	assign out_byte = out_q;

endmodule

// ===== hdl/a5_1_stream_cipher_core.sv =====
// A5/1-style stream cipher core. Each request on the input channel carries one data byte and a
// frame_start flag; each request on the output channel returns that byte XORed with the next
// eight keystream bits, the first bit in the LSB. Program cipher_key (index 0) and
// frame_number (index 1, low 22 bits kept) through the config port while the core is idle;
// they take effect at the next frame_start. Without any frame_start since reset the
// keystream is all zeros. A byte without frame_start is accepted and then clocks out its
// eight keystream bits; with frame_start the accept also clears the registers, and the 64
// key bits, the IV_BITS frame bits and the warmup majority clocks come before them. The
// datapath makes a single LFSR update per cycle, one load bit or one majority clock, unless
// the last clock of a byte stalls. The output register lets a result wait while the next
// byte is taken; the last keystream clock of a byte stalls only if the previous result still sits there.
module a5_1_stream_cipher_core import a51_pkg::*; #(
	parameter int WARMUP_CLOCKS = 100,  // majority clocks after loading, 0..255
	parameter int IV_BITS       = 22    // frame number bits loaded, 1..22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input requests
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  frame_start,
	// output requests
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	// config writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	a51_cmd_t cmd;

	// registers can always be written; unknown indexes are dropped in the datapath
	assign cfg_ready = 1'b1;

	// sequencer: load, warmup and keystream phases
	a51_ctrl #(
		.WARMUP_CLOCKS (WARMUP_CLOCKS),
		.IV_BITS       (IV_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd)
	);

	// three LFSRs, config registers, keystream and result byte
	a51_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_byte  (out_byte)
	);

endmodule
